// ===== rtl/cpwe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpwe_pkg
// Shared types and constants for the cassette pulse wave encoder.
// ----------------------------------------------------------------------------
package cpwe_pkg;

    localparam int CfgWidth   = 16;
    localparam int CountWidth = 16;
    localparam int HalfWidth  = 4;
    localparam int PosWidth   = 5;
    localparam int BitIdxWidth = 3;
    localparam int ByteWidth  = 8;
    localparam int SampleWidth = 16;

    localparam logic [CountWidth-1:0] SILENCE_RESET = 16'd12000;
    localparam logic [CountWidth-1:0] LEADER_RESET  = 16'd10000;
    localparam logic [CountWidth-1:0] IMAGE_RESET   = 16'd7680;
    localparam logic [HalfWidth-1:0]  ONE_HALF_RESET  = 4'd4;
    localparam logic [HalfWidth-1:0]  ZERO_HALF_RESET = 4'd2;

    localparam logic signed [SampleWidth-1:0] LVL_ZERO = 16'sh0000;
    localparam logic signed [SampleWidth-1:0] LVL_HIGH = 16'sh7FFF;
    localparam logic signed [SampleWidth-1:0] LVL_LOW  = 16'sh8000;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_PUSH  = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        CFG_SILENCE   = 3'd0,
        CFG_LEADER    = 3'd1,
        CFG_IMAGE     = 3'd2,
        CFG_ONE_HALF  = 3'd3,
        CFG_ZERO_HALF = 3'd4
    } cfg_idx_t;

    typedef enum logic [6:0] {
        PH_IDLE    = 7'b0000001,
        PH_SILENCE = 7'b0000010,
        PH_LEADER  = 7'b0000100,
        PH_SYNC    = 7'b0001000,
        PH_DATA    = 7'b0010000,
        PH_CKSUM   = 7'b0100000,
        PH_DONE    = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic signed [SampleWidth-1:0] lvl;
        logic [PosWidth-1:0]           pos;
        logic                          fin;
    } pulse_res_t;

    typedef struct packed {
        logic signed [SampleWidth-1:0] lvl;
        logic [PosWidth-1:0]           pos;
        logic [BitIdxWidth-1:0]        bit_index;
        logic                          fin;
    } byte_res_t;

    // one sample of a bit pulse: high for half samples, then low for half
    function automatic pulse_res_t pulse_step(
        input logic                 bit_val,
        input logic [PosWidth-1:0]  pos,
        input logic [HalfWidth-1:0] one_half,
        input logic [HalfWidth-1:0] zero_half
    );
        pulse_res_t           res;
        logic [HalfWidth-1:0] half;
        logic [PosWidth-1:0]  np;
        half = bit_val ? one_half : zero_half;
        if (half == '0)
        begin
            half = HalfWidth'(1);
        end
        res.lvl = (pos < {1'b0, half}) ? LVL_HIGH : LVL_LOW;
        np = pos + PosWidth'(1);
        res.fin = 1'b0;
        if (np >= {half, 1'b0})
        begin
            np = '0;
            res.fin = 1'b1;
        end
        res.pos = np;
        return res;
    endfunction

    // one sample of a byte, msb first; fin at the end of the last bit
    function automatic byte_res_t byte_step(
        input logic [ByteWidth-1:0]   shift_byte,
        input logic [BitIdxWidth-1:0] bit_index,
        input logic [PosWidth-1:0]    pos,
        input logic [HalfWidth-1:0]   one_half,
        input logic [HalfWidth-1:0]   zero_half
    );
        byte_res_t  res;
        pulse_res_t pr;
        pr = pulse_step(shift_byte[~bit_index], pos, one_half, zero_half);
        res.lvl = pr.lvl;
        res.pos = pr.pos;
        res.bit_index = bit_index;
        res.fin = 1'b0;
        if (pr.fin)
        begin
            res.bit_index = bit_index + BitIdxWidth'(1);
            res.fin = (res.bit_index == '0);
        end
        return res;
    endfunction

endpackage

// ===== rtl/cpwe_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpwe_in_if
// Command channel: command code and data byte with valid/ready.
// ----------------------------------------------------------------------------
interface cpwe_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] data_byte;

    modport source (output valid, output cmd, output data_byte, input ready);
    modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

// ===== rtl/cpwe_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpwe_out_if
// Sample channel: one tape sample and its status flags with valid/ready.
// ----------------------------------------------------------------------------
interface cpwe_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               byte_wanted;
    logic               underrun;
    logic               done_res;

    modport source (
        output valid, output sample, output byte_wanted, output underrun,
        output done_res, input ready
    );
    modport sink (
        input valid, input sample, input byte_wanted, input underrun,
        input done_res, output ready
    );
endinterface

// ===== rtl/cassette_pulse_wave_encoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cassette_pulse_wave_encoder_core
// Cassette tape waveform generator, one 16-bit sample per tick command.
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries commands: start tape, push data byte, sample tick.
//   each tick beat yields exactly one beat on out_ch (sample plus flags);
//   start and push beats update state only and give no output beat.
//   the tape is silence, a leader of one bits, a zero sync bit, the data
//   bytes msb first, then the 8-bit additive checksum byte.
//   latency: a tick accepted at one edge shows its sample on out_ch from
//   the next cycle. throughput: one command per cycle, set by the single
//   sequencer pass that updates the tape position and the output register.
//   stall: while out_ch holds an untaken beat and its ready is low, in_ch
//   ready drops; otherwise a new command is taken as the held beat leaves.
//   byte_wanted asks the host for a push; a tick that needs a byte and finds
//   none emits zero, flags underrun and leaves the tape position unchanged.
//   cfg_we/cfg_index/cfg_data write the timing registers; the user must do so
//   while idle, not enforced by the block. reset: registers take their default
//   timing, phase goes idle, the holding register empties and out_ch is empty.
// ----------------------------------------------------------------------------
module cassette_pulse_wave_encoder_core (
    input  logic                          clk,
    input  logic                          rst_n,
    cpwe_in_if.sink                       in_ch,
    cpwe_out_if.source                    out_ch,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_index,
    input  logic [cpwe_pkg::CfgWidth-1:0] cfg_data
);

    // configuration
    logic [cpwe_pkg::CountWidth-1:0] silence_reg, leader_reg, image_reg;
    logic [cpwe_pkg::HalfWidth-1:0]  one_half_reg, zero_half_reg;

    // tape state
    cpwe_pkg::phase_t                 phase_reg, phase_next;
    logic [cpwe_pkg::CountWidth-1:0]  run_count_reg, run_count_next;
    logic [cpwe_pkg::BitIdxWidth-1:0] bit_index_reg, bit_index_next;
    logic [cpwe_pkg::PosWidth-1:0]    pulse_pos_reg, pulse_pos_next;
    logic [cpwe_pkg::ByteWidth-1:0]   shift_byte_reg, shift_byte_next;
    logic [cpwe_pkg::ByteWidth-1:0]   held_byte_reg, held_byte_next;
    logic                             held_valid_reg, held_valid_next;
    logic [cpwe_pkg::ByteWidth-1:0]   running_sum_reg, running_sum_next;
    logic [cpwe_pkg::CountWidth-1:0]  bytes_left_reg, bytes_left_next;

    // output register
    logic                                     out_valid_reg;
    logic signed [cpwe_pkg::SampleWidth-1:0]  sample_reg, sample_next;
    logic                                     byte_wanted_reg, byte_wanted_next;
    logic                                     underrun_reg, underrun_next;
    logic                                     done_reg, done_next;

    logic                  in_fire;
    logic                  tick_fire;
    logic                  fin;
    logic                  running;
    cpwe_pkg::pulse_res_t  pr;
    cpwe_pkg::byte_res_t   br;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign tick_fire   = in_fire && (in_ch.cmd == cpwe_pkg::CMD_TICK);

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.sample      = sample_reg;
    assign out_ch.byte_wanted = byte_wanted_reg;
    assign out_ch.underrun    = underrun_reg;
    assign out_ch.done_res    = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            silence_reg   <= cpwe_pkg::SILENCE_RESET;
            leader_reg    <= cpwe_pkg::LEADER_RESET;
            image_reg     <= cpwe_pkg::IMAGE_RESET;
            one_half_reg  <= cpwe_pkg::ONE_HALF_RESET;
            zero_half_reg <= cpwe_pkg::ZERO_HALF_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cpwe_pkg::CFG_SILENCE:   silence_reg   <= cfg_data;
                cpwe_pkg::CFG_LEADER:    leader_reg    <= cfg_data;
                cpwe_pkg::CFG_IMAGE:     image_reg     <= cfg_data;
                cpwe_pkg::CFG_ONE_HALF:  one_half_reg  <= cfg_data[cpwe_pkg::HalfWidth-1:0];
                cpwe_pkg::CFG_ZERO_HALF: zero_half_reg <= cfg_data[cpwe_pkg::HalfWidth-1:0];
                default: ;
            endcase
        end
    end

    // one pass of the tape sequencer; phases only move forward, so a
    // finished section falls through into the next within the same beat
    always_comb
    begin
        phase_next       = phase_reg;
        run_count_next   = run_count_reg;
        bit_index_next   = bit_index_reg;
        pulse_pos_next   = pulse_pos_reg;
        shift_byte_next  = shift_byte_reg;
        held_byte_next   = held_byte_reg;
        held_valid_next  = held_valid_reg;
        running_sum_next = running_sum_reg;
        bytes_left_next  = bytes_left_reg;
        sample_next      = cpwe_pkg::LVL_ZERO;
        underrun_next    = 1'b0;
        fin              = 1'b0;
        pr               = '0;
        br               = '0;

        case (in_ch.cmd)
            cpwe_pkg::CMD_START:
            begin
                phase_next       = cpwe_pkg::PH_SILENCE;
                run_count_next   = '0;
                bit_index_next   = '0;
                pulse_pos_next   = '0;
                shift_byte_next  = '0;
                held_valid_next  = 1'b0;
                running_sum_next = '0;
                bytes_left_next  = image_reg;
            end
            cpwe_pkg::CMD_PUSH:
            begin
                held_byte_next  = in_ch.data_byte;
                held_valid_next = 1'b1;
            end
            cpwe_pkg::CMD_TICK:
            begin
                if (phase_next == cpwe_pkg::PH_SILENCE)
                begin
                    if (run_count_next < silence_reg)
                    begin
                        run_count_next = run_count_next + cpwe_pkg::CountWidth'(1);
                        fin = 1'b1;
                    end
                    else
                    begin
                        phase_next     = cpwe_pkg::PH_LEADER;
                        run_count_next = '0;
                        pulse_pos_next = '0;
                    end
                end
                if (!fin && phase_next == cpwe_pkg::PH_LEADER)
                begin
                    if (run_count_next < leader_reg)
                    begin
                        pr = cpwe_pkg::pulse_step(1'b1, pulse_pos_next,
                                                  one_half_reg, zero_half_reg);
                        sample_next    = pr.lvl;
                        pulse_pos_next = pr.pos;
                        if (pr.fin)
                        begin
                            run_count_next = run_count_next + cpwe_pkg::CountWidth'(1);
                        end
                        fin = 1'b1;
                    end
                    else
                    begin
                        phase_next     = cpwe_pkg::PH_SYNC;
                        pulse_pos_next = '0;
                    end
                end
                if (!fin && phase_next == cpwe_pkg::PH_SYNC)
                begin
                    pr = cpwe_pkg::pulse_step(1'b0, pulse_pos_next,
                                              one_half_reg, zero_half_reg);
                    sample_next    = pr.lvl;
                    pulse_pos_next = pr.pos;
                    if (pr.fin)
                    begin
                        phase_next     = cpwe_pkg::PH_DATA;
                        bit_index_next = '0;
                    end
                    fin = 1'b1;
                end
                if (!fin && phase_next == cpwe_pkg::PH_DATA)
                begin
                    // byte boundary: load next byte, else underrun or checksum
                    if (bit_index_next == '0 && pulse_pos_next == '0)
                    begin
                        if (bytes_left_next == '0)
                        begin
                            phase_next      = cpwe_pkg::PH_CKSUM;
                            shift_byte_next = running_sum_next;
                        end
                        else if (!held_valid_next)
                        begin
                            underrun_next = 1'b1;
                            fin = 1'b1;
                        end
                        else
                        begin
                            shift_byte_next  = held_byte_next;
                            held_valid_next  = 1'b0;
                            running_sum_next = running_sum_next + held_byte_next;
                            bytes_left_next  = bytes_left_next - cpwe_pkg::CountWidth'(1);
                        end
                    end
                    if (!fin && phase_next == cpwe_pkg::PH_DATA)
                    begin
                        br = cpwe_pkg::byte_step(shift_byte_next, bit_index_next,
                                                 pulse_pos_next, one_half_reg,
                                                 zero_half_reg);
                        sample_next    = br.lvl;
                        pulse_pos_next = br.pos;
                        bit_index_next = br.bit_index;
                        fin = 1'b1;
                    end
                end
                if (!fin && phase_next == cpwe_pkg::PH_CKSUM)
                begin
                    br = cpwe_pkg::byte_step(shift_byte_next, bit_index_next,
                                             pulse_pos_next, one_half_reg,
                                             zero_half_reg);
                    sample_next    = br.lvl;
                    pulse_pos_next = br.pos;
                    bit_index_next = br.bit_index;
                    if (br.fin)
                    begin
                        phase_next = cpwe_pkg::PH_DONE;
                    end
                    fin = 1'b1;
                end
            end
            default: ;
        endcase

        running = (phase_next == cpwe_pkg::PH_SILENCE) ||
                  (phase_next == cpwe_pkg::PH_LEADER)  ||
                  (phase_next == cpwe_pkg::PH_SYNC)    ||
                  (phase_next == cpwe_pkg::PH_DATA);
        byte_wanted_next = running && !held_valid_next && (bytes_left_next != '0);
        done_next        = (phase_next == cpwe_pkg::PH_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= cpwe_pkg::PH_IDLE;
            run_count_reg   <= '0;
            bit_index_reg   <= '0;
            pulse_pos_reg   <= '0;
            shift_byte_reg  <= '0;
            held_byte_reg   <= '0;
            held_valid_reg  <= 1'b0;
            running_sum_reg <= '0;
            bytes_left_reg  <= '0;
        end
        else if (in_fire)
        begin
            phase_reg       <= phase_next;
            run_count_reg   <= run_count_next;
            bit_index_reg   <= bit_index_next;
            pulse_pos_reg   <= pulse_pos_next;
            shift_byte_reg  <= shift_byte_next;
            held_byte_reg   <= held_byte_next;
            held_valid_reg  <= held_valid_next;
            running_sum_reg <= running_sum_next;
            bytes_left_reg  <= bytes_left_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (tick_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_fire)
        begin
            sample_reg      <= sample_next;
            byte_wanted_reg <= byte_wanted_next;
            underrun_reg    <= underrun_next;
            done_reg        <= done_next;
        end
    end

    // a tick beat always leaves a sample beat behind it
    a_tick_gives_beat : assert property (@(posedge clk) disable iff (!rst_n)
        tick_fire |=> out_valid_reg)
        else $error("tick beat produced no output beat");

    // an underrun beat carries a silent sample and never claims done
    a_underrun_silent : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && underrun_reg) |-> (sample_reg == cpwe_pkg::LVL_ZERO && !done_reg))
        else $error("underrun beat with nonzero sample or done");

    // a push always leaves a byte held
    a_push_holds : assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_ch.cmd == cpwe_pkg::CMD_PUSH) |=> held_valid_reg)
        else $error("pushed byte not held");

    // done and a request for more data never appear together
    a_done_no_want : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && done_reg) |-> (!byte_wanted_reg && !underrun_reg))
        else $error("done beat still asks for data");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cassette pulse wave encoder core. A short
// stimulus table covers idle ticks, underrun, byte overwrite, restart, a
// checksum-only tape and the register extremes. Random tapes with random
// timing follow. Untyped sample beats are checked against a cycle-free model.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int RAND_ITEMS = 1850;
    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               byte_wanted;
        logic               underrun;
        logic               done_res;
    } tape_sample_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        cpwe_pkg::cfg_idx_t idx;
        logic [15:0]        val;
        cpwe_pkg::cmd_t     cmd;
        logic [7:0]         data;
        logic [7:0]         reps;
        logic               typed;
        tape_sample_t       want;
    } step_row_t;

    localparam tape_sample_t NO_SAMPLE = '0;
    localparam int NUM_ROWS = 25;

    // typed rows: idle tick, silence tick, underrun, tick after done
    localparam step_row_t DIR_ROWS [NUM_ROWS] = '{
        '{ROW_ITEM, cpwe_pkg::CFG_SILENCE, 16'd0, cpwe_pkg::CMD_TICK, 8'h00, 8'd1, 1'b1,
          '{cpwe_pkg::LVL_ZERO, 1'b0, 1'b0, 1'b0}},
        '{ROW_ITEM, cpwe_pkg::CFG_SILENCE, 16'd0, cpwe_pkg::CMD_NONE, 8'hA5, 8'd1, 1'b0,
          NO_SAMPLE},
        '{ROW_ITEM, cpwe_pkg::CFG_SILENCE, 16'd0, cpwe_pkg::CMD_START, 8'h00, 8'd1, 1'b0,
          NO_SAMPLE},
        '{ROW_ITEM, cpwe_pkg::CFG_SILENCE, 16'd0, cpwe_pkg::CMD_TICK, 8'h00, 8'd1, 1'b1,
          '{cpwe_pkg::LVL_ZERO, 1'b1, 1'b0, 1'b0}},
        // shrink the tape while it is still in silence
        '{ROW_CFG, cpwe_pkg::CFG_SILENCE, 16'd0, cpwe_pkg::CMD_NONE, 8'h00, 8'd0, 1'b0,
          NO_SAMPLE},
        '{ROW_CFG, cpwe_pkg::CFG_LEADER, 16'd0, cpwe_pkg::CMD_NONE, 8'h00, 8'd0, 1'b0,
          NO_SAMPLE},
        '{ROW_CFG, cpwe_pkg::CFG_IMAGE, 16'd0, cpwe_pkg::CMD_NONE, 8'h00, 8'd0, 1'b0,
          NO_SAMPLE},
        '{ROW_CFG, cpwe_pkg::CFG_ONE_HALF, 16'd2, cpwe_pkg::CMD_NONE, 8'h00, 8'd0, 1'b0,
          NO_SAMPLE},
        '{ROW_CFG, cpwe_pkg::CFG_ZERO_HALF, 16'd0, cpwe_pkg::CMD_NONE, 8'h00, 8'd0, 1'b0,
          NO_SAMPLE},
        '{ROW_ITEM, cpwe_pkg::CFG_SILENCE, 16'd0, cpwe_pkg::CMD_TICK, 8'h00, 8'd2, 1'b0,
          NO_SAMPLE},
        '{ROW_ITEM, cpwe_pkg::CFG_SILENCE, 16'd0, cpwe_pkg::CMD_TICK, 8'h00, 8'd1, 1'b1,
          '{cpwe_pkg::LVL_ZERO, 1'b1, 1'b1, 1'b0}},
        '{ROW_ITEM, cpwe_pkg::CFG_SILENCE, 16'd0, cpwe_pkg::CMD_PUSH, 8'h00, 8'd1, 1'b0,
          NO_SAMPLE},
        '{ROW_ITEM, cpwe_pkg::CFG_SILENCE, 16'd0, cpwe_pkg::CMD_PUSH, 8'hFF, 8'd1, 1'b0,
          NO_SAMPLE},
        '{ROW_ITEM, cpwe_pkg::CFG_SILENCE, 16'd0, cpwe_pkg::CMD_TICK, 8'h00, 8'd2, 1'b0,
          NO_SAMPLE},
        // restart with no data bytes: sync then checksum only
        '{ROW_ITEM, cpwe_pkg::CFG_SILENCE, 16'd0, cpwe_pkg::CMD_START, 8'h00, 8'd1, 1'b0,
          NO_SAMPLE},
        '{ROW_ITEM, cpwe_pkg::CFG_SILENCE, 16'd0, cpwe_pkg::CMD_PUSH, 8'h5A, 8'd1, 1'b0,
          NO_SAMPLE},
        '{ROW_ITEM, cpwe_pkg::CFG_SILENCE, 16'd0, cpwe_pkg::CMD_TICK, 8'h00, 8'd18, 1'b0,
          NO_SAMPLE},
        '{ROW_ITEM, cpwe_pkg::CFG_SILENCE, 16'd0, cpwe_pkg::CMD_TICK, 8'h00, 8'd1, 1'b1,
          '{cpwe_pkg::LVL_ZERO, 1'b0, 1'b0, 1'b1}},
        '{ROW_CFG, cpwe_pkg::CFG_SILENCE, 16'hFFFF, cpwe_pkg::CMD_NONE, 8'h00, 8'd0, 1'b0,
          NO_SAMPLE},
        '{ROW_CFG, cpwe_pkg::CFG_LEADER, 16'hFFFF, cpwe_pkg::CMD_NONE, 8'h00, 8'd0, 1'b0,
          NO_SAMPLE},
        '{ROW_CFG, cpwe_pkg::CFG_IMAGE, 16'hFFFF, cpwe_pkg::CMD_NONE, 8'h00, 8'd0, 1'b0,
          NO_SAMPLE},
        '{ROW_CFG, cpwe_pkg::CFG_ONE_HALF, 16'hF, cpwe_pkg::CMD_NONE, 8'h00, 8'd0, 1'b0,
          NO_SAMPLE},
        '{ROW_CFG, cpwe_pkg::CFG_ZERO_HALF, 16'hF, cpwe_pkg::CMD_NONE, 8'h00, 8'd0, 1'b0,
          NO_SAMPLE},
        '{ROW_ITEM, cpwe_pkg::CFG_SILENCE, 16'd0, cpwe_pkg::CMD_START, 8'h00, 8'd1, 1'b0,
          NO_SAMPLE},
        '{ROW_ITEM, cpwe_pkg::CFG_SILENCE, 16'd0, cpwe_pkg::CMD_TICK, 8'h00, 8'd1, 1'b1,
          '{cpwe_pkg::LVL_ZERO, 1'b1, 1'b0, 1'b0}}
    };

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    cpwe_in_if  in_ch ();
    cpwe_out_if out_ch ();

    cassette_pulse_wave_encoder_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // tape model state
    logic [15:0]      silence_len;
    logic [15:0]      leader_len;
    logic [15:0]      image_len;
    logic [3:0]       one_half;
    logic [3:0]       zero_half;
    cpwe_pkg::phase_t tp_phase;
    logic [15:0]      run_cnt;
    logic [2:0]       bit_idx;
    logic [4:0]       pulse_pos;
    logic [7:0]       shift_reg;
    logic [7:0]       hold_reg;
    logic             hold_full;
    logic [7:0]       cksum;
    logic [15:0]      bytes_left;

    tape_sample_t pending_samples [$];
    int           mismatch_count;
    int           rand_items;
    bit           hold_req;

    function automatic void tape_reset();
        silence_len = cpwe_pkg::SILENCE_RESET;
        leader_len  = cpwe_pkg::LEADER_RESET;
        image_len   = cpwe_pkg::IMAGE_RESET;
        one_half    = cpwe_pkg::ONE_HALF_RESET;
        zero_half   = cpwe_pkg::ZERO_HALF_RESET;
        tp_phase    = cpwe_pkg::PH_IDLE;
        run_cnt     = '0;
        bit_idx     = '0;
        pulse_pos   = '0;
        shift_reg   = '0;
        hold_reg    = '0;
        hold_full   = 1'b0;
        cksum       = '0;
        bytes_left  = '0;
    endfunction

    function automatic logic byte_wanted_now();
        return (tp_phase inside {cpwe_pkg::PH_SILENCE, cpwe_pkg::PH_LEADER,
                                 cpwe_pkg::PH_SYNC, cpwe_pkg::PH_DATA})
            && !hold_full && (bytes_left != 16'd0);
    endfunction

    // one sample of a pulse; high for half samples then low, returns bit end
    function automatic logic pulse_tick(input logic bit_val, output logic signed [15:0] lvl);
        logic [4:0] half;
        half = {1'b0, bit_val ? one_half : zero_half};
        if (half == 5'd0)
        begin
            half = 5'd1;
        end
        lvl = (pulse_pos < half) ? cpwe_pkg::LVL_HIGH : cpwe_pkg::LVL_LOW;
        pulse_pos = pulse_pos + 5'd1;
        if (pulse_pos >= {half[3:0], 1'b0})
        begin
            pulse_pos = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // msb first; returns byte end
    function automatic logic byte_tick(output logic signed [15:0] lvl);
        if (pulse_tick(shift_reg[3'd7 - bit_idx], lvl))
        begin
            bit_idx = bit_idx + 3'd1;
            return bit_idx == 3'd0;
        end
        return 1'b0;
    endfunction

    function automatic logic signed [15:0] tape_tick(output logic under);
        logic signed [15:0] lvl;
        lvl = cpwe_pkg::LVL_ZERO;
        under = 1'b0;
        // finished sections fall through to the next one in the same tick
        repeat (4)
        begin
            case (tp_phase)
                cpwe_pkg::PH_SILENCE:
                    if (run_cnt < silence_len)
                    begin
                        run_cnt = run_cnt + 16'd1;
                        return cpwe_pkg::LVL_ZERO;
                    end
                    else
                    begin
                        tp_phase = cpwe_pkg::PH_LEADER;
                        run_cnt = '0;
                        pulse_pos = '0;
                    end
                cpwe_pkg::PH_LEADER:
                    if (run_cnt < leader_len)
                    begin
                        if (pulse_tick(1'b1, lvl))
                        begin
                            run_cnt = run_cnt + 16'd1;
                        end
                        return lvl;
                    end
                    else
                    begin
                        tp_phase = cpwe_pkg::PH_SYNC;
                        pulse_pos = '0;
                    end
                cpwe_pkg::PH_SYNC:
                begin
                    if (pulse_tick(1'b0, lvl))
                    begin
                        tp_phase = cpwe_pkg::PH_DATA;
                        bit_idx = '0;
                    end
                    return lvl;
                end
                cpwe_pkg::PH_DATA:
                    if (bit_idx == 3'd0 && pulse_pos == 5'd0 && bytes_left == 16'd0)
                    begin
                        tp_phase = cpwe_pkg::PH_CKSUM;
                        shift_reg = cksum;
                    end
                    else
                    begin
                        if (bit_idx == 3'd0 && pulse_pos == 5'd0)
                        begin
                            if (!hold_full)
                            begin
                                under = 1'b1;
                                return cpwe_pkg::LVL_ZERO;
                            end
                            shift_reg = hold_reg;
                            hold_full = 1'b0;
                            cksum = cksum + hold_reg;
                            bytes_left = bytes_left - 16'd1;
                        end
                        void'(byte_tick(lvl));
                        return lvl;
                    end
                cpwe_pkg::PH_CKSUM:
                begin
                    if (byte_tick(lvl))
                    begin
                        tp_phase = cpwe_pkg::PH_DONE;
                    end
                    return lvl;
                end
                default:
                    return cpwe_pkg::LVL_ZERO;
            endcase
        end
        return cpwe_pkg::LVL_ZERO;
    endfunction

    function automatic logic tape_step(input cpwe_pkg::cmd_t c, input logic [7:0] d,
                                       output tape_sample_t res);
        logic under;
        res = '0;
        case (c)
            cpwe_pkg::CMD_START:
            begin
                tp_phase   = cpwe_pkg::PH_SILENCE;
                run_cnt    = '0;
                bit_idx    = '0;
                pulse_pos  = '0;
                shift_reg  = '0;
                hold_full  = 1'b0;
                cksum      = '0;
                bytes_left = image_len;
                return 1'b0;
            end
            cpwe_pkg::CMD_PUSH:
            begin
                hold_reg  = d;
                hold_full = 1'b1;
                return 1'b0;
            end
            cpwe_pkg::CMD_TICK:
            begin
                res.sample      = tape_tick(under);
                res.underrun    = under;
                res.byte_wanted = byte_wanted_now();
                res.done_res    = (tp_phase == cpwe_pkg::PH_DONE);
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic logic [15:0] pick_count(input int max_val);
        if ($urandom_range(0, 15) == 0)
        begin
            return 16'hFFFF;
        end
        return 16'($urandom_range(0, max_val));
    endfunction

    function automatic logic [15:0] pick_half();
        int r;
        r = $urandom_range(0, 11);
        if (r == 0)
        begin
            return 16'd0;
        end
        if (r == 1)
        begin
            return 16'd15;
        end
        return 16'($urandom_range(1, 3));
    endfunction

    task automatic send_item(input cpwe_pkg::cmd_t c, input logic [7:0] d,
                             input logic typed = 1'b0,
                             input tape_sample_t typed_want = '0);
        tape_sample_t pred;
        @(negedge clk);
        in_ch.valid     = 1'b1;
        in_ch.cmd       = c;
        in_ch.data_byte = d;
        do
        begin
            @(posedge clk);
        end
        while (!in_ch.ready);
        if (tape_step(c, d, pred))
        begin
            pending_samples.push_back(typed ? typed_want : pred);
        end
    endtask

    task automatic gap(input int n);
        repeat (n)
        begin
            @(negedge clk);
            in_ch.valid     = 1'b0;
            in_ch.cmd       = 2'($urandom_range(0, 3));
            in_ch.data_byte = 8'($urandom_range(0, 255));
        end
    endtask

    // drop valid and wait until every sample beat has been taken
    task automatic settle();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (pending_samples.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (3) @(posedge clk);
    endtask

    task automatic set_reg(input cpwe_pkg::cfg_idx_t idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        case (idx)
            cpwe_pkg::CFG_SILENCE:   silence_len = val;
            cpwe_pkg::CFG_LEADER:    leader_len = val;
            cpwe_pkg::CFG_IMAGE:     image_len = val;
            cpwe_pkg::CFG_ONE_HALF:  one_half = val[3:0];
            cpwe_pkg::CFG_ZERO_HALF: zero_half = val[3:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver: changing stall patterns plus one long hold-off
    initial
    begin
        int mode;
        int mode_left;
        int beat_cnt;
        mode = 0;
        mode_left = 0;
        beat_cnt = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 160);
            end
            mode_left--;
            beat_cnt++;
            case (mode)
                0: out_ch.ready = 1'b1;
                1: out_ch.ready = ($urandom_range(0, 3) != 0);
                2: out_ch.ready = ($urandom_range(0, 3) == 0);
                default: out_ch.ready = (beat_cnt % 5) < 2;
            endcase
        end
    end

    always @(posedge clk)
    begin
        tape_sample_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_samples.size() == 0)
            begin
                $error("sample beat %0d with nothing expected", out_ch.sample);
                mismatch_count++;
            end
            else
            begin
                want = pending_samples.pop_front();
                if (out_ch.sample !== want.sample)
                begin
                    $error("sample: expected %0d, got %0d", want.sample, out_ch.sample);
                    mismatch_count++;
                end
                if (out_ch.byte_wanted !== want.byte_wanted)
                begin
                    $error("byte_wanted: expected %0b, got %0b",
                           want.byte_wanted, out_ch.byte_wanted);
                    mismatch_count++;
                end
                if (out_ch.underrun !== want.underrun)
                begin
                    $error("underrun: expected %0b, got %0b", want.underrun, out_ch.underrun);
                    mismatch_count++;
                end
                if (out_ch.done_res !== want.done_res)
                begin
                    $error("done_res: expected %0b, got %0b", want.done_res, out_ch.done_res);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int             r;
        int             cap;
        int             post_done;
        int             burst_left;
        int             n_phase;
        int             wait_cnt;
        bit             gaps_on;
        cpwe_pkg::cmd_t c;
        logic [7:0]     d;
        mismatch_count = 0;
        rand_items = 0;
        in_ch.valid = 1'b0;
        in_ch.cmd = cpwe_pkg::CMD_NONE;
        in_ch.data_byte = '0;
        cfg_we = 1'b0;
        cfg_index = cpwe_pkg::CFG_SILENCE;
        cfg_data = '0;
        tape_reset();
        rst_n = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < NUM_ROWS; i++)
        begin
            if (DIR_ROWS[i].kind == ROW_CFG)
            begin
                settle();
                set_reg(DIR_ROWS[i].idx, DIR_ROWS[i].val);
            end
            else
            begin
                repeat (DIR_ROWS[i].reps)
                begin
                    send_item(DIR_ROWS[i].cmd, DIR_ROWS[i].data, DIR_ROWS[i].typed,
                              DIR_ROWS[i].want);
                end
            end
        end

        // random tapes, each under a fresh register setting
        n_phase = 0;
        burst_left = 0;
        while (rand_items < RAND_ITEMS)
        begin
            settle();
            set_reg(cpwe_pkg::CFG_SILENCE, pick_count(6));
            set_reg(cpwe_pkg::CFG_LEADER, pick_count(3));
            set_reg(cpwe_pkg::CFG_IMAGE, pick_count(5));
            set_reg(cpwe_pkg::CFG_ONE_HALF, pick_half());
            set_reg(cpwe_pkg::CFG_ZERO_HALF, pick_half());
            gaps_on = ($urandom_range(0, 3) != 0);
            if (n_phase == 2)
            begin
                // sender keeps offering while the receiver holds off
                gaps_on = 1'b0;
                hold_req = 1'b1;
            end
            cap = 400;
            post_done = $urandom_range(1, 3);
            send_item(cpwe_pkg::CMD_START, 8'($urandom_range(0, 255)));
            rand_items++;
            while (cap > 0 && post_done > 0 && rand_items < RAND_ITEMS)
            begin
                if (gaps_on)
                begin
                    if (burst_left == 0)
                    begin
                        gap($urandom_range(1, 8));
                        burst_left = $urandom_range(1, 24);
                    end
                    burst_left--;
                end
                r = $urandom_range(0, 99);
                d = 8'($urandom_range(0, 255));
                if (r < 2)
                begin
                    send_item(cpwe_pkg::CMD_NONE, d);
                end
                else
                begin
                    if (r < 3)
                    begin
                        c = cpwe_pkg::CMD_START;
                    end
                    else if (byte_wanted_now())
                    begin
                        // skipping a wanted byte now and then gives underruns
                        c = (r < 52) ? cpwe_pkg::CMD_PUSH : cpwe_pkg::CMD_TICK;
                    end
                    else if (r < 7)
                    begin
                        c = cpwe_pkg::CMD_PUSH;
                    end
                    else
                    begin
                        c = cpwe_pkg::CMD_TICK;
                    end
                    if (tp_phase == cpwe_pkg::PH_DONE && c == cpwe_pkg::CMD_TICK)
                    begin
                        post_done--;
                    end
                    send_item(c, d);
                    rand_items++;
                    cap--;
                end
            end
            n_phase++;
        end

        @(negedge clk);
        in_ch.valid = 1'b0;
        wait_cnt = 0;
        while (pending_samples.size() != 0 && wait_cnt < 1000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (8) @(posedge clk);
        if (pending_samples.size() != 0)
        begin
            $error("%0d expected sample beats never came out", pending_samples.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== cassette_pulse_wave_encoder_core.f =====
rtl/cpwe_pkg.sv
rtl/cpwe_in_if.sv
rtl/cpwe_out_if.sv
rtl/cassette_pulse_wave_encoder_core.sv
test/tb_top.sv
